// ----- rtl/pc_sample_range_histogram_assert.svh -----
// ----------------------------------------------------------------------------
// pc_sample_range_histogram_assert.svh - assertion macros
// Shared property wrappers, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef PC_SAMPLE_RANGE_HISTOGRAM_ASSERT_SVH
`define PC_SAMPLE_RANGE_HISTOGRAM_ASSERT_SVH

// Same-cycle implication.
`define PSRH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PSRH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/psrh_pkg.sv -----
// ----------------------------------------------------------------------------
// psrh_pkg - PC sample histogram package
// Fixed constants, register indexes and command codes.
// ----------------------------------------------------------------------------
package psrh_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ADDRESS_BITS = 32;
  // bin size in bytes, a power of two
  localparam int unsigned BIN_BYTES    = 16;
  localparam int unsigned BIN_SHIFT    = $clog2(BIN_BYTES);
  localparam logic [DATA_W-1:0] BIN_MASK = DATA_W'(BIN_BYTES - 1);
  localparam logic [DATA_W-1:0] ADDR_MASK =
      (ADDRESS_BITS >= DATA_W) ? {DATA_W{1'b1}}
                               : DATA_W'((64'd1 << ADDRESS_BITS) - 64'd1);
  localparam int unsigned CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ENABLE   = 3'd0,
    CFG_R0_FIRST = 3'd1,
    CFG_R0_LAST  = 3'd2,
    CFG_R1_FIRST = 3'd3,
    CFG_R1_LAST  = 3'd4
  } cfg_index_t;

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    PH_CLEAR = 2'b01,
    PH_RUN   = 2'b10
  } phase_t;

endpackage

// ----- rtl/psrh_ram.sv -----
// ----------------------------------------------------------------------------
// psrh_ram - generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module psrh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/pc_sample_range_histogram.sv -----
// ----------------------------------------------------------------------------
// pc_sample_range_histogram - program counter sampling histogram
// Counts sampled addresses in 16-byte bins over two address windows, with
// saturating counts kept in one RAM, and serves single-bin reads.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Signals                          Beat contents
// s_       in   s_tvalid s_tready s_tdata s_tuser  one record or read command
// m_       out  m_tvalid m_tready m_tdata m_tuser  one result per command
// cfg_     in   cfg_we cfg_index cfg_data          one register write
//
// Cycles: 2 per command. Decode (window match, bin) takes one cycle, the
//   count RAM read a second; the update is written back as the result
//   leaves, the same edge that takes the next command. The single RAM
//   read-modify-write sets the rate.
// Reset: after rst the RAM is swept to zero, one entry a cycle, for
//   2 * 2**clog2(BINS_PER_WINDOW) cycles (8192 by default); s_tready stays
//   low during the sweep. Config writes are taken at any time.
// Stalls: with m_tready low the result holds in the output register; one
//   more command is read and then waits for the output to free up.
// ----------------------------------------------------------------------------
`include "pc_sample_range_histogram_assert.svh"

module pc_sample_range_histogram #(
  parameter int unsigned BINS_PER_WINDOW = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // input commands
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [31:0] sample_address, [32] read_window,
                                 // [44:33] read_bin, [47:45] zero
  input  logic        s_tuser,   // [0] cmd
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] bin_count, [63:32] bin_base
  output logic [2:0]  m_tuser,   // [0] sample_hit, [1] hit_window,
                                 // [2] sample_dropped
  // configuration
  input  logic                             cfg_we,
  input  logic [psrh_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [psrh_pkg::DATA_W-1:0]      cfg_data
);

  localparam int unsigned DW        = psrh_pkg::DATA_W;
  localparam int unsigned BIN_W     = $clog2(BINS_PER_WINDOW);
  localparam int unsigned RAM_AW    = BIN_W + 1;
  localparam int unsigned RAM_DEPTH = 1 << RAM_AW;
  localparam logic [DW-1:0] BINS_LIMIT = DW'(BINS_PER_WINDOW);

  // decoded command handed from decode to update
  typedef struct packed {
    logic              hit;       // counted, in store
    logic              drop;      // in a window, beyond store
    logic              miss;      // disabled or no window: all zero result
    logic              win;
    logic              in_store;
    logic [RAM_AW-1:0] ram_addr;
    logic [DW-1:0]     offset;    // bin base minus window start
  } upd_t;

  // ---------------------------------------------------------------- config
  logic          enable;
  logic [DW-1:0] r0_first, r0_last, r1_first, r1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable   <= 1'b0;
      r0_first <= '0;
      r0_last  <= '0;
      r1_first <= '0;
      r1_last  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        psrh_pkg::CFG_ENABLE:   enable   <= cfg_data[0];
        psrh_pkg::CFG_R0_FIRST: r0_first <= cfg_data;
        psrh_pkg::CFG_R0_LAST:  r0_last  <= cfg_data;
        psrh_pkg::CFG_R1_FIRST: r1_first <= cfg_data;
        psrh_pkg::CFG_R1_LAST:  r1_last  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- clear sweep
  psrh_pkg::phase_t  phase;
  logic [RAM_AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= psrh_pkg::PH_CLEAR;
      clr_addr <= '0;
    end else if (phase == psrh_pkg::PH_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
      if (&clr_addr) begin
        phase <= psrh_pkg::PH_RUN;
      end
    end
  end

  // ------------------------------------------------------------ handshake
  logic s1_valid, s2_valid, s2_done;
  logic in_beat;

  assign s2_done  = s2_valid && (!m_tvalid || m_tready);
  // one command in flight; the next enters as the current one retires
  assign s_tready = (phase == psrh_pkg::PH_RUN) && !s1_valid && (!s2_valid || s2_done);
  assign in_beat  = s_tvalid && s_tready;

  // --------------------------------------------------------- decode stage
  logic          s1_cmd;
  logic [DW-1:0] s1_addr;
  logic          s1_rwin;
  logic [11:0]   s1_rbin;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_cmd  <= s_tuser;
      s1_addr <= s_tdata[31:0];
      s1_rwin <= s_tdata[32];
      s1_rbin <= s_tdata[44:33];
    end
  end

  logic [DW-1:0] a, f0, l0, f1, l1, d0, d1, diff, rec_bin, rd_bin, bin;
  logic          in0, in1, matched, is_read, win, in_store;
  upd_t          upd_next;

  always_comb begin
    a  = s1_addr  & psrh_pkg::ADDR_MASK;
    f0 = r0_first & psrh_pkg::ADDR_MASK;
    l0 = r0_last  & psrh_pkg::ADDR_MASK;
    f1 = r1_first & psrh_pkg::ADDR_MASK;
    l1 = r1_last  & psrh_pkg::ADDR_MASK;
    // an empty window (first >= last) never matches
    in0 = enable && (a >= f0) && (a < l0);
    in1 = enable && (a >= f1) && (a < l1);
    matched = in0 || in1;
    d0 = a - f0;
    d1 = a - f1;
    diff    = in0 ? d0 : d1;          // window 0 wins
    rec_bin = diff >> psrh_pkg::BIN_SHIFT;
    rd_bin  = DW'(s1_rbin);
    is_read = (s1_cmd == psrh_pkg::CMD_READ);
    bin      = is_read ? rd_bin : rec_bin;
    win      = is_read ? s1_rwin : !in0;
    in_store = (bin < BINS_LIMIT);

    upd_next.hit      = !is_read && matched && in_store;
    upd_next.drop     = !is_read && matched && !in_store;
    upd_next.miss     = !is_read && !matched;
    upd_next.win      = win && !upd_next.miss;
    upd_next.in_store = in_store;
    upd_next.ram_addr = {win, bin[BIN_W-1:0]};
    upd_next.offset   = is_read ? (rd_bin << psrh_pkg::BIN_SHIFT)
                                : (diff & ~psrh_pkg::BIN_MASK);
  end

  // --------------------------------------------------------- update stage
  upd_t upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_valid) begin
      s2_valid <= 1'b1;
    end else if (s2_done) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      upd <= upd_next;
    end
  end

  // ----------------------------------------------------------- count RAM
  logic              ram_we, ram_re;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0]     ram_wdata, ram_rdata;

  logic [DW-1:0] count_sat, count_out, base_out, first_sel;

  always_comb begin
    // saturating increment
    count_sat = (&ram_rdata) ? ram_rdata : ram_rdata + 1'b1;
    if (upd.hit) begin
      count_out = count_sat;
    end else if (upd.drop || upd.miss || !upd.in_store) begin
      count_out = '0;
    end else begin
      count_out = ram_rdata;
    end
    first_sel = upd.win ? r1_first : r0_first;
    base_out  = upd.miss ? '0
                         : ((first_sel + upd.offset) & psrh_pkg::ADDR_MASK);
  end

  always_comb begin
    if (phase == psrh_pkg::PH_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = s2_done && upd.hit;
      ram_waddr = upd.ram_addr;
      ram_wdata = count_sat;
    end
    ram_re    = s1_valid;
    ram_raddr = upd_next.ram_addr;
  end

  psrh_ram #(
    .WIDTH (DW),
    .DEPTH (RAM_DEPTH)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // -------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_done) begin
      m_tdata <= {base_out, count_out};
      m_tuser <= {upd.drop, upd.win, upd.hit};
    end
  end

  // ------------------------------------------------------------ assertions
  `PSRH_ASSERT_NEXT(a_single_in_flight, in_beat, s1_valid && !s2_valid, "second command in flight")
  `PSRH_ASSERT_NOW(a_no_rmw_overlap, ram_we && ram_re, ram_waddr != ram_raddr, "RAM read and write overlap")
  `PSRH_ASSERT_NOW(a_hit_xor_drop, m_tvalid, !(m_tuser[0] && m_tuser[2]), "hit and drop both set")
  `PSRH_ASSERT_NOW(a_hit_nonzero, m_tvalid && m_tuser[0], m_tdata[31:0] != '0, "hit with zero count")

endmodule

// ----- test/pc_sample_range_histogram_test.sv -----
// ----------------------------------------------------------------------------
// pc_sample_range_histogram_test - self-checking bench for the PC histogram
// Drives record and read commands through the input stream, keeps its own
// copy of both count stores and window registers, and checks every result
// beat field by field. Both stream sides idle at random; one phase holds the
// output off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module pc_sample_range_histogram_test;

  localparam int unsigned BINS        = 4096;
  // longest run of cycles with no beat on either side; covers the RAM sweep
  localparam int unsigned QUIET_LIMIT = 40000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic        hit;
    logic        win;
    logic        drop;
    logic [31:0] count;
    logic [31:0] base;
  } bin_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // [31:0] sample_address, [32] read_window,
                          // [44:33] read_bin, [47:45] zero
  logic        s_tuser;   // [0] cmd
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // [31:0] bin_count, [63:32] bin_base
  logic [2:0]  m_tuser;   // [0] sample_hit, [1] hit_window, [2] sample_dropped
  logic                             cfg_we;
  logic [psrh_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [psrh_pkg::DATA_W-1:0]      cfg_data;

  pc_sample_range_histogram #(
    .BINS_PER_WINDOW(BINS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow of the block: register copies and both count stores.
  logic        sampling_on;
  logic [31:0] win_first [2];
  logic [31:0] win_last  [2];
  logic [31:0] bin_tally [2][BINS];

  bin_result_t expected_bins [$];

  // Idle shaping: max gap per beat on each side, and a one-shot long hold.
  int unsigned src_max_gap;
  int unsigned sink_max_gap;
  bit          hold_request;

  int unsigned mismatches;
  int unsigned n_counted, n_dropped, n_missed, n_reads, n_checked;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bin update for one command. Counts saturate at all ones; that level is
  // out of reach in a run this short, but the shadow still honors it.
  function automatic bin_result_t tally_command(input psrh_pkg::cmd_t cmd,
                                                input logic [31:0] addr,
                                                input logic rwin,
                                                input logic [11:0] rbin);
    bin_result_t r;
    logic [31:0] bin;
    r = '0;
    if (cmd == psrh_pkg::CMD_READ) begin
      r.win   = rwin;
      r.count = bin_tally[rwin][rbin];
      r.base  = win_first[rwin] + 32'(rbin) * psrh_pkg::BIN_BYTES;
      return r;
    end
    if (!sampling_on) return r;
    // first matching window wins; an empty window (first >= last) never matches
    for (int w = 0; w < 2; w++) begin
      if (addr >= win_first[w] && addr < win_last[w]) begin
        bin    = (addr - win_first[w]) >> psrh_pkg::BIN_SHIFT;
        r.win  = 1'(w);
        r.base = win_first[w] + bin * psrh_pkg::BIN_BYTES;
        if (bin >= BINS) begin
          // past the store: flagged, and the other window is not tried
          r.drop = 1'b1;
          return r;
        end
        if (bin_tally[w][bin[11:0]] != 32'hFFFF_FFFF)
          bin_tally[w][bin[11:0]] += 32'd1;
        r.hit   = 1'b1;
        r.count = bin_tally[w][bin[11:0]];
        return r;
      end
    end
    return r;
  endfunction

  // One command beat. Entered and left at a falling edge; tvalid is left high
  // so a back-to-back beat needs no second assignment in the same step.
  task automatic send_cmd(input psrh_pkg::cmd_t cmd, input logic [31:0] addr,
                          input logic rwin, input logic [11:0] rbin);
    int unsigned gap;
    bin_result_t r;
    gap = (src_max_gap == 0) ? 0 : $urandom_range(src_max_gap, 0);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {3'b000, rbin, rwin, addr};
    s_tuser  <= cmd;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!(s_tvalid && s_tready)) @(posedge clk);
    r = tally_command(cmd, addr, rwin, rbin);
    expected_bins.push_back(r);
    if (cmd == psrh_pkg::CMD_READ) n_reads++;
    else if (r.hit) n_counted++;
    else if (r.drop) n_dropped++;
    else n_missed++;
    @(negedge clk);
  endtask

  // unused fields of each command carry random bits
  task automatic sample_at(input logic [31:0] addr);
    send_cmd(psrh_pkg::CMD_RECORD, addr, 1'($urandom), 12'($urandom));
  endtask

  task automatic query_bin(input logic w, input logic [11:0] b);
    send_cmd(psrh_pkg::CMD_READ, $urandom, w, b);
  endtask

  // Quiesce: stop offering, wait for every result, then cover the write-back.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_bins.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input psrh_pkg::cfg_index_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // Writes all five registers; only called with the block idle.
  task automatic load_windows(input logic en, input logic [31:0] f0, input logic [31:0] l0,
                              input logic [31:0] f1, input logic [31:0] l1);
    write_reg(psrh_pkg::CFG_ENABLE, {31'b0, en});
    write_reg(psrh_pkg::CFG_R0_FIRST, f0);
    write_reg(psrh_pkg::CFG_R0_LAST, l0);
    write_reg(psrh_pkg::CFG_R1_FIRST, f1);
    write_reg(psrh_pkg::CFG_R1_LAST, l1);
    cfg_we       <= 1'b0;
    sampling_on  = en;
    win_first[0] = f0;
    win_last[0]  = l0;
    win_first[1] = f1;
    win_last[1]  = l1;
  endtask

  // Mix: reads of hot and random bins, stray addresses, hot bins hit
  // back to back, beats near the store edge and anywhere in a window.
  task automatic random_traffic(input int unsigned n_cmds);
    int unsigned pick, w;
    logic [31:0] span, offset;
    repeat (n_cmds) begin
      pick = $urandom_range(99, 0);
      w    = $urandom_range(1, 0);
      span = win_last[w] - win_first[w];
      if (pick < 25) begin
        if ($urandom_range(1, 0)) query_bin(1'(w), 12'($urandom_range(7, 0)));
        else query_bin(1'(w), 12'($urandom));
      end else if (pick < 38 || win_last[w] <= win_first[w]) begin
        sample_at($urandom);
      end else begin
        if (pick < 80)
          offset = $urandom_range((span - 1 < 127) ? span - 1 : 127, 0);
        else if (pick < 90)
          offset = BINS * psrh_pkg::BIN_BYTES - 64 + $urandom_range(127, 0);
        else
          offset = $urandom_range(span - 1, 0);
        if (offset >= span) offset = span - 1;
        sample_at(win_first[w] + offset);
      end
    end
  endtask

  // --- directed tests ------------------------------------------------------

  // Sampling off: records leave every field zero even inside a window;
  // reads still answer.
  task automatic test_sampling_off();
    load_windows(1'b0, 32'h0000_1000, 32'h0000_2000, 32'h0000_0000, 32'hFFFF_FFFF);
    sample_at(32'h0000_1000);
    sample_at(32'hFFFF_FFFF);
    query_bin(1'b0, 12'd0);
    query_bin(1'b1, 12'hFFF);
    settle();
  endtask

  // Window 0 with a drop region past its store, window 1 overlapping it.
  task automatic test_window_match();
    load_windows(1'b1, 32'h0001_0000, 32'h0002_0040, 32'h0000_8000, 32'h0003_0000);
    sample_at(32'h0001_0000);          // first byte of window 0
    sample_at(32'h0001_0000);          // same bin back to back
    sample_at(32'h0001_000F);
    sample_at(32'h0001_FFF5);          // last bin in store
    sample_at(32'h0002_0000);          // first bin past store: dropped
    sample_at(32'h0002_003F);          // last byte of window 0, dropped
    sample_at(32'h0002_0040);          // window 0 end is exclusive; window 1 drops it
    sample_at(32'h0000_8000);          // window 1 only
    sample_at(32'h0001_8000);          // overlap: window 0 wins
    sample_at(32'h0000_7FFF);          // below both
    sample_at(32'h0003_0000);          // above both
    query_bin(1'b0, 12'd0);
    query_bin(1'b0, 12'hFFF);
    query_bin(1'b1, 12'd0);
    settle();
  endtask

  // Empty windows, a window touching the top of the address space, a base
  // that wraps past zero, and a window spanning everything.
  task automatic test_edges();
    load_windows(1'b1, 32'h0000_5000, 32'h0000_5000, 32'hFFFF_F000, 32'hFFFF_FFFF);
    sample_at(32'h0000_5000);          // empty window never matches
    sample_at(32'hFFFF_FFFE);
    sample_at(32'hFFFF_FFFF);          // exclusive end
    query_bin(1'b1, 12'hFFF);          // base wraps
    settle();
    load_windows(1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0010, 32'h0000_0008);
    sample_at(32'h0000_0000);
    sample_at(32'hFFFF_FFFE);          // dropped, base near the top
    settle();
  endtask

  // --- random tests --------------------------------------------------------

  // Hot bins at full rate on both sides: back-to-back updates of one bin.
  task automatic test_hot_bins_streaming();
    load_windows(1'b1, 32'h0040_0000, 32'h0041_0100, 32'h0040_8000, 32'h0042_0000);
    src_max_gap  = 0;
    sink_max_gap = 0;
    random_traffic(250);
    settle();
  endtask

  // Random idling on both sides, with one long output hold at the start.
  task automatic test_backpressure();
    load_windows(1'b1, 32'h8000_0007, 32'h8001_0000, 32'h7FFF_F003, 32'h8000_4000);
    src_max_gap  = 6;
    sink_max_gap = 6;
    hold_request = 1'b1;
    random_traffic(250);
    settle();
  endtask

  // A tiny window 0 ahead of a window 1 that covers nearly all addresses.
  task automatic test_large_windows();
    load_windows(1'b1, 32'h0000_0000, 32'h0000_8000, 32'h0000_4000, 32'hFFFF_FFFF);
    random_traffic(250);
    settle();
  endtask

  // Sampling off with live windows: counts freeze, reads keep answering.
  task automatic test_disabled_reads();
    load_windows(1'b0, 32'h0040_0000, 32'h0041_0100, 32'h0000_0000, 32'h0000_8000);
    random_traffic(150);
    settle();
  endtask

  // Random window bounds of assorted sizes, in and out of idle stretches.
  task automatic test_random_windows();
    int unsigned k;
    logic [31:0] f0, f1, s0, s1;
    for (k = 0; k < 7; k++) begin
      f0 = $urandom;
      f1 = $urandom_range(1, 0) ? f0 + $urandom_range(4096, 0) : $urandom;
      s0 = (k % 3 == 0) ? $urandom_range(1024, 0)
                        : BINS * psrh_pkg::BIN_BYTES - 256 + $urandom_range(512, 0);
      s1 = (k % 3 == 2) ? $urandom : $urandom_range(BINS * psrh_pkg::BIN_BYTES, 0);
      load_windows(1'b1, f0, f0 + s0, f1, f1 + s1);
      src_max_gap  = (k % 2) ? 6 : 0;
      sink_max_gap = (k % 3) ? 6 : 0;
      random_traffic(50);
      settle();
    end
  endtask

  // --- result side ---------------------------------------------------------

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, name, want, got);
    end
  endtask

  // Output ready: random stall per beat, plus one long hold on request.
  initial begin : result_sink
    int unsigned stall;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      stall = (sink_max_gap == 0) ? 0 : $urandom_range(sink_max_gap, 0);
      if (hold_request) begin
        stall        = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
    end
  end

  // Each result beat against the oldest waiting expectation.
  initial begin : result_check
    bin_result_t want;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        n_checked++;
        if (expected_bins.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing expected, actual tdata 0x%016h tuser %b",
                   $time, m_tdata, m_tuser);
        end else begin
          want = expected_bins.pop_front();
          report_field("sample_hit", 32'(want.hit), 32'(m_tuser[0]));
          report_field("hit_window", 32'(want.win), 32'(m_tuser[1]));
          report_field("sample_dropped", 32'(want.drop), 32'(m_tuser[2]));
          report_field("bin_count", want.count, m_tdata[31:0]);
          report_field("bin_base", want.base, m_tdata[63:32]);
        end
      end
    end
  end

  // Ends the run if no beat moves on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
             $time, quiet, expected_bins.size());
    $display("simulation failed");
    $finish;
  end

  initial begin : run
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = psrh_pkg::CFG_ENABLE;
    cfg_data     = '0;
    src_max_gap  = 6;
    sink_max_gap = 6;
    hold_request = 1'b0;
    mismatches   = 0;
    n_counted    = 0;
    n_dropped    = 0;
    n_missed     = 0;
    n_reads      = 0;
    n_checked    = 0;
    sampling_on  = 1'b0;
    for (int w = 0; w < 2; w++) begin
      win_first[w] = '0;
      win_last[w]  = '0;
      for (int b = 0; b < BINS; b++) bin_tally[w][b] = '0;
    end
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    // the first beat waits out the store sweep on s_tready

    test_sampling_off();
    test_window_match();
    test_edges();
    test_hot_bins_streaming();
    test_backpressure();
    test_large_windows();
    test_disabled_reads();
    test_random_windows();

    settle();
    repeat (8) @(negedge clk);
    $display("commands: %0d counted, %0d dropped past store, %0d unmatched or off, %0d reads",
             n_counted, n_dropped, n_missed, n_reads);
    $display("result beats checked: %0d, mismatches: %0d, left waiting: %0d",
             n_checked, mismatches, expected_bins.size());
    if (mismatches == 0 && expected_bins.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
